// ----- hw/rtl/circle_pair_elastic_collision_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the circle pair elastic collision unit
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_PAIR_ELASTIC_COLLISION_UNIT_DEFINES_SVH
`define CIRCLE_PAIR_ELASTIC_COLLISION_UNIT_DEFINES_SVH

// same-cycle implication
`define CPEC_ASSERT_NOW(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// next-cycle implication
`define CPEC_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

// ----- hw/rtl/cpec_pkg.sv -----
// ----------------------------------------------------------------------------
// cpec_pkg
// Widths and shared types of the circle pair elastic collision unit.
// ----------------------------------------------------------------------------
package cpec_pkg;

	localparam int POS_W = 20;
	localparam int VEL_W = 16;
	localparam int RAD_W = 8;
	localparam int LANES = 4;
	localparam int MAG_W = 62;
	localparam int DEN_W = 43;
	localparam int QUO_W = 19;

	typedef struct packed {
		logic                    hit;
		logic signed [VEL_W-1:0] vx1;
		logic signed [VEL_W-1:0] vy1;
		logic signed [VEL_W-1:0] vx2;
		logic signed [VEL_W-1:0] vy2;
	} side_t;

	typedef struct packed {
		logic                        vld;
		logic [LANES-1:0][MAG_W-1:0] mag;
		logic [DEN_W-1:0]            den;
		logic [LANES-1:0]            neg;
		side_t                       side;
	} div_in_t;

	typedef struct packed {
		logic                        vld;
		logic [LANES-1:0][QUO_W-1:0] quo;
		logic [LANES-1:0]            neg;
		side_t                       side;
	} div_out_t;

endpackage

// ----- hw/rtl/circle_pair_elastic_collision_unit.sv -----
// ----------------------------------------------------------------------------
// circle_pair_elastic_collision_unit
// Overlap test and elastic velocity exchange for one pair of circles.
// ----------------------------------------------------------------------------
// One pair enters every cycle while the output is not stalled, and passes through
// seven arithmetic stages, a 19-stage restoring divider that yields one quotient
// bit per stage for all four correction terms, and one output stage. The
// whole pipeline holds while a result waits at the output, so in_ready
// follows out_ready whenever the output register is full.
// ----------------------------------------------------------------------------
`include "circle_pair_elastic_collision_unit_defines.svh"

module circle_pair_elastic_collision_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [cpec_pkg::POS_W-1:0] first_x,
	input  logic signed [cpec_pkg::POS_W-1:0] first_y,
	input  logic signed [cpec_pkg::VEL_W-1:0] first_vx,
	input  logic signed [cpec_pkg::VEL_W-1:0] first_vy,
	input  logic        [cpec_pkg::RAD_W-1:0] first_radius,
	input  logic signed [cpec_pkg::POS_W-1:0] second_x,
	input  logic signed [cpec_pkg::POS_W-1:0] second_y,
	input  logic signed [cpec_pkg::VEL_W-1:0] second_vx,
	input  logic signed [cpec_pkg::VEL_W-1:0] second_vy,
	input  logic        [cpec_pkg::RAD_W-1:0] second_radius,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic signed [cpec_pkg::VEL_W-1:0] new_first_vx,
	output logic signed [cpec_pkg::VEL_W-1:0] new_first_vy,
	output logic signed [cpec_pkg::VEL_W-1:0] new_second_vx,
	output logic signed [cpec_pkg::VEL_W-1:0] new_second_vy
);

	logic en;
	cpec_pkg::div_in_t  dq_in;
	cpec_pkg::div_out_t dq;

	// advance unless a result is held at the output
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	cpec_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.vld           (in_valid),
		.first_x       (first_x),
		.first_y       (first_y),
		.first_vx      (first_vx),
		.first_vy      (first_vy),
		.first_radius  (first_radius),
		.second_x      (second_x),
		.second_y      (second_y),
		.second_vx     (second_vx),
		.second_vy     (second_vy),
		.second_radius (second_radius),
		.dout          (dq_in)
	);

	cpec_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.din    (dq_in),
		.dout   (dq)
	);

	cpec_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.din           (dq),
		.vld           (out_valid),
		.hit           (hit),
		.new_first_vx  (new_first_vx),
		.new_first_vy  (new_first_vy),
		.new_second_vx (new_second_vx),
		.new_second_vy (new_second_vy)
	);

	`CPEC_ASSERT_NOW(a_stall_blocks_input, out_valid && !out_ready, !in_ready, "input taken during stall")
	`CPEC_ASSERT_NEXT(a_stall_holds_div, !in_ready, $stable(dq.quo), "divider moved during stall")
	`CPEC_ASSERT_NOW(a_quo_range, dq.vld && dq.side.hit, !dq.quo[0][cpec_pkg::QUO_W-1] && !dq.quo[1][cpec_pkg::QUO_W-1] && !dq.quo[2][cpec_pkg::QUO_W-1] && !dq.quo[3][cpec_pkg::QUO_W-1], "correction out of range")

endmodule

// ----- hw/rtl/cpec_front.sv -----
// ----------------------------------------------------------------------------
// cpec_front
// Seven stages: differences, squares and dot terms, overlap test, mass
// scaling, partial products, numerators, rounded magnitudes.
// ----------------------------------------------------------------------------
module cpec_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 vld,
	input  logic signed [cpec_pkg::POS_W-1:0]    first_x,
	input  logic signed [cpec_pkg::POS_W-1:0]    first_y,
	input  logic signed [cpec_pkg::VEL_W-1:0]    first_vx,
	input  logic signed [cpec_pkg::VEL_W-1:0]    first_vy,
	input  logic        [cpec_pkg::RAD_W-1:0]    first_radius,
	input  logic signed [cpec_pkg::POS_W-1:0]    second_x,
	input  logic signed [cpec_pkg::POS_W-1:0]    second_y,
	input  logic signed [cpec_pkg::VEL_W-1:0]    second_vx,
	input  logic signed [cpec_pkg::VEL_W-1:0]    second_vy,
	input  logic        [cpec_pkg::RAD_W-1:0]    second_radius,
	output cpec_pkg::div_in_t                    dout
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	logic signed [20:0] dx_s1, dy_s1;
	logic signed [16:0] dvx_s1, dvy_s1;
	logic [8:0] rsum_s1;
	logic [7:0] r1_s1, r2_s1;
	cpec_pkg::side_t side_s1;

	logic [40:0] dxx_s2, dyy_s2;
	logic signed [37:0] pdx_s2, pdy_s2;
	logic [17:0] rsq_s2;
	logic signed [17:0] dx_s2, dy_s2;
	logic [8:0] rsum_s2;
	logic [7:0] r1_s2, r2_s2;
	cpec_pkg::side_t side_s2;

	logic [33:0] dist2_s3;
	logic signed [34:0] dot_s3;
	logic signed [17:0] dx_s3, dy_s3;
	logic [8:0] rsum_s3;
	logic [7:0] r1_s3, r2_s3;
	cpec_pkg::side_t side_s3;

	logic [42:0] den_s4;
	logic signed [42:0] k1_s4, k2_s4;
	logic signed [17:0] dx_s4, dy_s4;
	cpec_pkg::side_t side_s4;

	logic signed [40:0] plo_s5 [cpec_pkg::LANES];
	logic signed [38:0] phi_s5 [cpec_pkg::LANES];
	logic [42:0] den_s5;
	cpec_pkg::side_t side_s5;

	logic signed [61:0] num_s6 [cpec_pkg::LANES];
	logic [42:0] den_s6;
	cpec_pkg::side_t side_s6;

	logic [cpec_pkg::LANES-1:0][cpec_pkg::MAG_W-1:0] mag_s7;
	logic [cpec_pkg::LANES-1:0] neg_s7;
	logic [42:0] den_s7;
	cpec_pkg::side_t side_s7;

	logic signed [41:0] sqx, sqy;
	logic [41:0] dist2;
	logic signed [38:0] dot;
	logic hit;
	logic signed [43:0] kp1, kp2;
	logic signed [40:0] plo [cpec_pkg::LANES];
	logic signed [38:0] phi [cpec_pkg::LANES];
	logic signed [61:0] num [cpec_pkg::LANES];
	logic [cpec_pkg::LANES-1:0][cpec_pkg::MAG_W-1:0] mag;
	logic [cpec_pkg::LANES-1:0] neg;

	always_comb begin
		logic signed [17:0] d;
		logic signed [42:0] k;
		logic signed [61:0] a, b;
		sqx   = dx_s1 * dx_s1;
		sqy   = dy_s1 * dy_s1;
		dist2 = {1'b0, dxx_s2} + {1'b0, dyy_s2};
		dot   = 39'(pdx_s2) + 39'(pdy_s2);
		hit   = (dist2 != '0) && (dist2 < {8'b0, rsq_s2, 16'b0});
		kp1   = dot_s3 * $signed({1'b0, r2_s3});
		kp2   = dot_s3 * $signed({1'b0, r1_s3});
		for (int l = 0; l < cpec_pkg::LANES; l++) begin
			d = (l % 2 == 0) ? dx_s4 : dy_s4;
			k = (l < 2) ? k1_s4 : k2_s4;
			plo[l] = d * $signed({1'b0, k[21:0]});
			phi[l] = d * $signed(k[42:22]);
			a = phi_s5[l];
			b = plo_s5[l];
			num[l] = (a <<< 23) + (b <<< 1);
			neg[l] = num_s6[l][61];
			mag[l] = (neg[l] ? 62'(-num_s6[l]) : 62'(num_s6[l])) + 62'(den_s6 >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= {second_x[19], second_x} - {first_x[19], first_x};
			dy_s1   <= {second_y[19], second_y} - {first_y[19], first_y};
			dvx_s1  <= {second_vx[15], second_vx} - {first_vx[15], first_vx};
			dvy_s1  <= {second_vy[15], second_vy} - {first_vy[15], first_vy};
			rsum_s1 <= {1'b0, first_radius} + {1'b0, second_radius};
			r1_s1   <= first_radius;
			r2_s1   <= second_radius;
			side_s1 <= '{hit: 1'b0, vx1: first_vx, vy1: first_vy,
				vx2: second_vx, vy2: second_vy};

			dxx_s2  <= sqx[40:0];
			dyy_s2  <= sqy[40:0];
			pdx_s2  <= dx_s1 * dvx_s1;
			pdy_s2  <= dy_s1 * dvy_s1;
			rsq_s2  <= rsum_s1 * rsum_s1;
			dx_s2   <= dx_s1[17:0];
			dy_s2   <= dy_s1[17:0];
			rsum_s2 <= rsum_s1;
			r1_s2   <= r1_s1;
			r2_s2   <= r2_s1;
			side_s2 <= side_s1;

			dist2_s3 <= dist2[33:0];
			dot_s3   <= dot[34:0];
			dx_s3    <= dx_s2;
			dy_s3    <= dy_s2;
			rsum_s3  <= rsum_s2;
			r1_s3    <= r1_s2;
			r2_s3    <= r2_s2;
			side_s3  <= '{hit: hit, vx1: side_s2.vx1, vy1: side_s2.vy1,
				vx2: side_s2.vx2, vy2: side_s2.vy2};

			den_s4  <= rsum_s3 * dist2_s3;
			k1_s4   <= kp1[42:0];
			k2_s4   <= kp2[42:0];
			dx_s4   <= dx_s3;
			dy_s4   <= dy_s3;
			side_s4 <= side_s3;

			plo_s5  <= plo;
			phi_s5  <= phi;
			den_s5  <= den_s4;
			side_s5 <= side_s4;

			num_s6  <= num;
			den_s6  <= den_s5;
			side_s6 <= side_s5;

			mag_s7  <= mag;
			neg_s7  <= neg;
			den_s7  <= den_s6;
			side_s7 <= side_s6;
		end
	end

	always_comb begin
		dout = '{vld: vld_s7, mag: mag_s7, den: den_s7, neg: neg_s7, side: side_s7};
	end

endmodule

// ----- hw/rtl/cpec_divider.sv -----
// ----------------------------------------------------------------------------
// cpec_divider
// Restoring divider, one quotient bit per stage, four lanes sharing a divisor.
// ----------------------------------------------------------------------------
module cpec_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  cpec_pkg::div_in_t  din,
	output cpec_pkg::div_out_t dout
);

	localparam int NS = cpec_pkg::QUO_W;

	logic [NS-1:0] vld_s;
	logic [cpec_pkg::LANES-1:0][cpec_pkg::MAG_W-1:0] rem_s [NS];
	logic [cpec_pkg::LANES-1:0][cpec_pkg::QUO_W-1:0] quo_s [NS];
	logic [cpec_pkg::DEN_W-1:0] den_s [NS];
	logic [cpec_pkg::LANES-1:0] neg_s [NS];
	cpec_pkg::side_t side_s [NS];

	for (genvar j = 0; j < NS; j++) begin : g_stage
		localparam int SH = NS - 1 - j;
		logic vld_in;
		logic [cpec_pkg::LANES-1:0][cpec_pkg::MAG_W-1:0] rem_in, rem_nx;
		logic [cpec_pkg::LANES-1:0][cpec_pkg::QUO_W-1:0] quo_in, quo_nx;
		logic [cpec_pkg::DEN_W-1:0] den_in;
		logic [cpec_pkg::LANES-1:0] neg_in;
		cpec_pkg::side_t side_in;
		logic [cpec_pkg::MAG_W-1:0] trial;

		if (j == 0) begin : g_first
			assign vld_in  = din.vld;
			assign rem_in  = din.mag;
			assign quo_in  = '0;
			assign den_in  = din.den;
			assign neg_in  = din.neg;
			assign side_in = din.side;
		end else begin : g_next
			assign vld_in  = vld_s[j-1];
			assign rem_in  = rem_s[j-1];
			assign quo_in  = quo_s[j-1];
			assign den_in  = den_s[j-1];
			assign neg_in  = neg_s[j-1];
			assign side_in = side_s[j-1];
		end

		assign trial = cpec_pkg::MAG_W'(den_in) << SH;

		always_comb begin
			rem_nx = rem_in;
			quo_nx = quo_in;
			for (int l = 0; l < cpec_pkg::LANES; l++) begin
				if (rem_in[l] >= trial) begin
					rem_nx[l]     = rem_in[l] - trial;
					quo_nx[l][SH] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= rem_nx;
				quo_s[j]  <= quo_nx;
				den_s[j]  <= den_in;
				neg_s[j]  <= neg_in;
				side_s[j] <= side_in;
			end
		end
	end

	assign dout.vld  = vld_s[NS-1];
	assign dout.quo  = quo_s[NS-1];
	assign dout.neg  = neg_s[NS-1];
	assign dout.side = side_s[NS-1];

endmodule

// ----- hw/rtl/cpec_back.sv -----
// ----------------------------------------------------------------------------
// cpec_back
// Apply signed corrections to the velocities, saturate and register result.
// ----------------------------------------------------------------------------
module cpec_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  cpec_pkg::div_out_t                din,
	output logic                              vld,
	output logic                              hit,
	output logic signed [cpec_pkg::VEL_W-1:0] new_first_vx,
	output logic signed [cpec_pkg::VEL_W-1:0] new_first_vy,
	output logic signed [cpec_pkg::VEL_W-1:0] new_second_vx,
	output logic signed [cpec_pkg::VEL_W-1:0] new_second_vy
);

	logic vld_q, hit_q;
	logic signed [cpec_pkg::VEL_W-1:0] nv_q [cpec_pkg::LANES];
	logic signed [cpec_pkg::VEL_W-1:0] nv [cpec_pkg::LANES];

	always_comb begin
		logic signed [cpec_pkg::QUO_W:0] corr;
		logic signed [cpec_pkg::VEL_W-1:0] v;
		logic signed [cpec_pkg::QUO_W+1:0] sum;
		for (int l = 0; l < cpec_pkg::LANES; l++) begin
			corr = din.neg[l] ? -$signed({1'b0, din.quo[l]}) : $signed({1'b0, din.quo[l]});
			case (l)
				0:       v = din.side.vx1;
				1:       v = din.side.vy1;
				2:       v = din.side.vx2;
				default: v = din.side.vy2;
			endcase
			if (l < 2) begin
				sum = (cpec_pkg::QUO_W+2)'(v) + (cpec_pkg::QUO_W+2)'(corr);
			end else begin
				sum = (cpec_pkg::QUO_W+2)'(v) - (cpec_pkg::QUO_W+2)'(corr);
			end
			if (!din.side.hit) begin
				nv[l] = v;
			end else if (sum > 32767) begin
				nv[l] = 16'sh7fff;
			end else if (sum < -32768) begin
				nv[l] = 16'sh8000;
			end else begin
				nv[l] = sum[cpec_pkg::VEL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q <= din.side.hit;
			nv_q  <= nv;
		end
	end

	assign vld           = vld_q;
	assign hit           = hit_q;
	assign new_first_vx  = nv_q[0];
	assign new_first_vy  = nv_q[1];
	assign new_second_vx = nv_q[2];
	assign new_second_vy = nv_q[3];

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the circle pair elastic collision unit against a built-in collision
// predictor. Directed pairs cover range extremes, coincident centres, zero
// radii, exact touching and saturation. Random pairs follow, most of them
// overlapping. Both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

	typedef logic signed [cpec_pkg::POS_W-1:0] pos_t;
	typedef logic signed [cpec_pkg::VEL_W-1:0] vel_t;
	typedef logic        [cpec_pkg::RAD_W-1:0] rad_t;

	typedef struct {
		pos_t x1, y1, x2, y2;
		vel_t vx1, vy1, vx2, vy2;
		rad_t r1, r2;
		int   gap;
		bit   drain;
	} pair_t;

	typedef struct {
		logic hit;
		vel_t vx1, vy1, vx2, vy2;
	} bounce_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	pos_t first_x = '0, first_y = '0, second_x = '0, second_y = '0;
	vel_t first_vx = '0, first_vy = '0, second_vx = '0, second_vy = '0;
	rad_t first_radius = '0, second_radius = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic hit;
	vel_t new_first_vx, new_first_vy, new_second_vx, new_second_vy;

	pair_t   pending_pairs[$];
	bounce_t bounce_q[$];
	pair_t   cur;
	int      gap_left = 0;
	int      stall_left = 0;
	bit      stall_burst = 0;
	int      fails = 0;
	int      pairs_sent = 0;
	int      bounces_seen = 0;
	int      hits_seen = 0;
	longint  cycles = 0;

	circle_pair_elastic_collision_unit DUT (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint round_div(longint num, longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic vel_t clamp_vel(longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[cpec_pkg::VEL_W-1:0];
	endfunction

	function automatic bounce_t collide(pair_t p);
		bounce_t b;
		longint dx, dy, d2, rs, dot, den, r1, r2;
		longint vx1, vy1, vx2, vy2;
		vx1 = longint'(p.vx1); vy1 = longint'(p.vy1);
		vx2 = longint'(p.vx2); vy2 = longint'(p.vy2);
		r1 = longint'(p.r1); r2 = longint'(p.r2);
		dx = longint'(p.x2) - longint'(p.x1);
		dy = longint'(p.y2) - longint'(p.y1);
		d2 = dx * dx + dy * dy;
		rs = r1 + r2;
		b.hit = 1'b0;
		b.vx1 = p.vx1; b.vy1 = p.vy1; b.vx2 = p.vx2; b.vy2 = p.vy2;
		if (d2 > 0 && d2 < ((rs * rs) << 16)) begin
			dot = dx * (vx2 - vx1) + dy * (vy2 - vy1);
			den = rs * d2;
			b.hit = 1'b1;
			b.vx1 = clamp_vel(vx1 + round_div(dx * dot * 2 * r2, den));
			b.vy1 = clamp_vel(vy1 + round_div(dy * dot * 2 * r2, den));
			b.vx2 = clamp_vel(vx2 - round_div(dx * dot * 2 * r1, den));
			b.vy2 = clamp_vel(vy2 - round_div(dy * dot * 2 * r1, den));
		end
		return b;
	endfunction

	function automatic pair_t make_pair(int x1, int y1, int vx1, int vy1, int r1,
			int x2, int y2, int vx2, int vy2, int r2);
		pair_t p;
		p.x1 = pos_t'(x1); p.y1 = pos_t'(y1);
		p.vx1 = vel_t'(vx1); p.vy1 = vel_t'(vy1); p.r1 = rad_t'(r1);
		p.x2 = pos_t'(x2); p.y2 = pos_t'(y2);
		p.vx2 = vel_t'(vx2); p.vy2 = vel_t'(vy2); p.r2 = rad_t'(r2);
		p.gap = 0;
		p.drain = 0;
		return p;
	endfunction

	function automatic pair_t random_pair(bit overlap);
		pair_t p;
		int rs, reach, dx, dy;
		p.x1 = pos_t'($urandom); p.y1 = pos_t'($urandom);
		p.x2 = pos_t'($urandom); p.y2 = pos_t'($urandom);
		p.vx1 = vel_t'($urandom); p.vy1 = vel_t'($urandom);
		p.vx2 = vel_t'($urandom); p.vy2 = vel_t'($urandom);
		p.r1 = rad_t'($urandom); p.r2 = rad_t'($urandom);
		if (overlap) begin
			if ($urandom_range(0, 3) == 0) begin
				p.r1 = rad_t'($urandom_range(1, 255));
				p.r2 = rad_t'($urandom_range(1, 255));
			end else begin
				p.r1 = rad_t'($urandom_range(1, 20));
				p.r2 = rad_t'($urandom_range(1, 20));
			end
			if ($urandom_range(0, 1)) begin
				p.vx1 = vel_t'(int'($urandom_range(0, 2047)) - 1024);
				p.vy1 = vel_t'(int'($urandom_range(0, 2047)) - 1024);
				p.vx2 = vel_t'(int'($urandom_range(0, 2047)) - 1024);
				p.vy2 = vel_t'(int'($urandom_range(0, 2047)) - 1024);
			end
			rs = int'(p.r1) + int'(p.r2);
			reach = rs * 181;
			dx = int'($urandom_range(0, 2 * reach)) - reach;
			dy = int'($urandom_range(0, 2 * reach)) - reach;
			p.x1 = pos_t'(int'($urandom_range(0, 800000)) - 400000);
			p.y1 = pos_t'(int'($urandom_range(0, 800000)) - 400000);
			p.x2 = pos_t'(int'(p.x1) + dx);
			p.y2 = pos_t'(int'(p.y1) + dy);
		end
		p.gap = 0;
		p.drain = 0;
		return p;
	endfunction

	function automatic void add_pair(pair_t p);
		pending_pairs.insert(pending_pairs.size(), p);
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				bounce_q.insert(bounce_q.size(), collide(cur));
				pairs_sent++;
			end
			if (in_valid && !in_ready) begin
				in_valid <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_pairs.size() > 0 &&
					!(pending_pairs[0].drain && bounce_q.size() != 0)) begin
				cur = pending_pairs.pop_front();
				gap_left = cur.gap;
				first_x <= cur.x1; first_y <= cur.y1;
				first_vx <= cur.vx1; first_vy <= cur.vy1; first_radius <= cur.r1;
				second_x <= cur.x2; second_y <= cur.y2;
				second_vx <= cur.vx2; second_vy <= cur.vy2; second_radius <= cur.r2;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		bounce_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				bounces_seen++;
				if (hit)
					hits_seen++;
				if (bounce_q.size() == 0) begin
					$error("result with no transaction pending");
					fails++;
				end else begin
					e = bounce_q.pop_front();
					if (hit !== e.hit) begin
						$error("hit: expected %0d, got %0d", e.hit, hit);
						fails++;
					end
					if (new_first_vx !== e.vx1) begin
						$error("new_first_vx: expected %0d, got %0d", e.vx1, new_first_vx);
						fails++;
					end
					if (new_first_vy !== e.vy1) begin
						$error("new_first_vy: expected %0d, got %0d", e.vy1, new_first_vy);
						fails++;
					end
					if (new_second_vx !== e.vx2) begin
						$error("new_second_vx: expected %0d, got %0d", e.vx2, new_second_vx);
						fails++;
					end
					if (new_second_vy !== e.vy2) begin
						$error("new_second_vy: expected %0d, got %0d", e.vy2, new_second_vy);
						fails++;
					end
				end
				if ($urandom_range(0, 40) == 0)
					stall_burst = !stall_burst;
				stall_left = stall_burst ? 0 : int'($urandom_range(0, 14));
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		pair_t p;
		bit burst;
		// no overlap, far apart
		add_pair(make_pair(0, 0, 100, -100, 10, 100000, 0, -5, 5, 10));
		// range extremes of position, no overlap
		add_pair(make_pair(524287, 524287, 32767, 32767, 255,
			-524288, -524288, -32768, -32768, 255));
		add_pair(make_pair(-524288, 524287, -32768, 32767, 1,
			524287, -524288, 32767, -32768, 1));
		// coincident centres
		add_pair(make_pair(1000, -2000, 300, 400, 50, 1000, -2000, -300, 7, 60));
		// both radii zero
		add_pair(make_pair(0, 0, 256, 0, 0, 1, 0, -256, 0, 0));
		// one radius zero
		add_pair(make_pair(0, 0, 256, 0, 0, 256, 0, -256, 0, 4));
		add_pair(make_pair(0, 0, 256, 0, 5, 256, 0, -256, 0, 0));
		// exactly touching, and one step inside
		add_pair(make_pair(0, 0, 512, 0, 3, 5 * 256, 0, -512, 0, 2));
		add_pair(make_pair(0, 0, 512, 0, 3, 5 * 256 - 1, 0, -512, 0, 2));
		// head-on, equal mass
		add_pair(make_pair(0, 0, 256, 0, 10, 2560, 0, -256, 0, 10));
		// diagonal, unequal mass
		add_pair(make_pair(100, 200, 300, -700, 7, 900, 1400, -50, 80, 40));
		// saturation at full speed and largest radii
		add_pair(make_pair(0, 0, 32767, 32767, 1, 256, 256, -32768, -32768, 255));
		add_pair(make_pair(0, 0, -32768, 0, 255, -256, 0, 32767, 0, 1));
		add_pair(make_pair(0, 0, 32767, -32768, 255, 1, -1, -32768, 32767, 255));
		// minimum distance step
		add_pair(make_pair(0, 0, 1000, 1000, 1, 0, 1, -1000, -1000, 1));
		// receding pair, still overlapping
		add_pair(make_pair(0, 0, -256, 0, 8, 1024, 0, 256, 0, 8));
		burst = 0;
		for (int i = 0; i < 550; i++) begin
			p = random_pair($urandom_range(0, 9) < 8);
			if ($urandom_range(0, 40) == 0)
				burst = !burst;
			p.gap = burst ? 0 : int'($urandom_range(0, 14));
			p.drain = (i % 150 == 75);
			add_pair(p);
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_pairs.size() == 0 && !in_valid && bounce_q.size() == 0);
		repeat (60) @(posedge clk);
		$display("Sent %0d circle pairs; %0d results checked, %0d of them collisions.",
			pairs_sent, bounces_seen, hits_seen);
		if (fails == 0 && bounce_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
